// ===== rtl/wpts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpts_pkg: shared types and constants
// Item layouts, opcodes and sequencer states of the weighted target selector.
// ----------------------------------------------------------------------------
package wpts_pkg;

    localparam int RND_W     = 64;
    localparam int MASK_BITS = 16;
    localparam int FIELD_GW  = 2;
    localparam int FIELD_SW  = 2;
    localparam int FIELD_WW  = 32;
    localparam int CFG_W     = 3;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic                 opcode;
        logic [RND_W-1:0]     random_word;
        logic [MASK_BITS-1:0] healthy_mask;
        logic [FIELD_GW-1:0]  entry_group;
        logic [FIELD_SW-1:0]  entry_slot;
        logic [FIELD_WW-1:0]  entry_weight;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [FIELD_GW-1:0] chosen_group;
        logic [FIELD_SW-1:0] chosen_slot;
        logic                fell_back;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_DIV  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

// ===== rtl/weighted_priority_target_select_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_priority_target_select_top: weighted pick with priority failover
// Weight table in RAM, serial modulo, walk over cumulative weights.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): a write item stores
//   one weight and gives no result; a select item gives one result on the
//   output channel (o_out_valid / i_out_stall / o_out_item).
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the number
//   of groups in use; write it only while no select is in flight.
//   A select reads each tried group from the single RAM read port, then
//   runs a bit-serial modulo of the 64-bit random word and walks the
//   chosen group again.
//   One select is worked on at a time; o_in_stall is high while it runs.
//   Reset clears the table (per-entry valid bits) and sets the group count
//   to 1. A finished result waits in the output register while the
//   receiver stalls; new items are accepted meanwhile, and the next result
//   waits for that register to free up.
// ----------------------------------------------------------------------------
module weighted_priority_target_select_top #(
    parameter int GROUPS      = 4,
    parameter int SLOTS       = 4,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  wpts_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output wpts_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [wpts_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int ENTRIES = GROUPS * SLOTS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int G_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOT_W   = WEIGHT_BITS + $clog2(SLOTS);
    localparam int HB_W    = ADDR_W + 4;

    wpts_pkg::t_state r_state, n_state;

    logic [wpts_pkg::CFG_W-1:0]     r_group_count;
    logic [ENTRIES-1:0]             r_valid;
    logic [wpts_pkg::RND_W-1:0]     r_rnd;
    logic [wpts_pkg::MASK_BITS-1:0] r_mask;
    logic [G_W-1:0]                 r_group, n_group;
    logic                           r_fb, n_fb;
    logic [SLOT_W-1:0]              r_slot, n_slot;
    logic                           r_issue, n_issue;
    logic                           r_rd_vld;
    logic [SLOT_W-1:0]              r_rd_slot;
    logic                           r_rd_last;
    logic                           r_rd_health;
    logic                           r_rd_vbit;
    logic [TOT_W-1:0]               r_total, n_total;
    logic [TOT_W-1:0]               r_sel, n_sel;
    logic                           r_found, n_found;
    logic [SLOT_W-1:0]              r_chosen, n_chosen;
    wpts_pkg::t_out_item            r_out;
    logic                           r_out_valid;

    logic                   in_acc;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [HB_W-1:0]        hbit;
    logic                   rd_health;
    logic [WEIGHT_BITS-1:0] ram_q;
    logic [WEIGHT_BITS-1:0] w_eff;
    logic [TOT_W-1:0]       w_ext;
    logic [TOT_W-1:0]       sum;
    logic [G_W-1:0]         last_group;
    logic                   mod_start;
    logic                   mod_done;
    logic [TOT_W-1:0]       mod_rem;
    logic                   walk_hit;
    logic                   out_load;

    assign o_in_stall  = (r_state != wpts_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign wr_en   = in_acc && (i_in_item.opcode == wpts_pkg::OP_WRITE)
                     && (32'(i_in_item.entry_group) < GROUPS)
                     && (32'(i_in_item.entry_slot) < SLOTS);
    assign wr_addr = ADDR_W'(32'(i_in_item.entry_group) * SLOTS
                             + 32'(i_in_item.entry_slot));

    assign rd_addr   = ADDR_W'(32'(r_group) * SLOTS + 32'(r_slot));
    assign hbit      = HB_W'(rd_addr);
    assign rd_health = (hbit < HB_W'(wpts_pkg::MASK_BITS)) ? r_mask[hbit[3:0]] : 1'b0;

    always_comb begin
        if (r_group_count == '0) begin
            last_group = '0;
        end else if (32'(r_group_count) > GROUPS) begin
            last_group = G_W'(GROUPS - 1);
        end else begin
            last_group = G_W'(r_group_count - 1'b1);
        end
    end

    wpts_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_in_item.entry_weight[WEIGHT_BITS-1:0]),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    wpts_mod #(
        .TOT_W (TOT_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (sum),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign w_eff    = (r_rd_vbit && (r_fb || r_rd_health)) ? ram_q : '0;
    assign w_ext    = TOT_W'(w_eff);
    assign sum      = r_total + w_ext;
    assign walk_hit = r_sel < w_ext;
    assign out_load = (r_state == wpts_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state   = r_state;
        n_group   = r_group;
        n_fb      = r_fb;
        n_slot    = r_slot;
        n_issue   = r_issue;
        n_total   = r_total;
        n_sel     = r_sel;
        n_found   = r_found;
        n_chosen  = r_chosen;
        mod_start = 1'b0;

        if (r_issue) begin
            if (r_slot == SLOT_W'(SLOTS - 1)) begin
                n_issue = 1'b0;
            end else begin
                n_slot = r_slot + 1'b1;
            end
        end

        unique case (r_state)
            wpts_pkg::S_IDLE: begin
                if (in_acc && (i_in_item.opcode == wpts_pkg::OP_SELECT)) begin
                    n_state  = wpts_pkg::S_SUM;
                    n_group  = '0;
                    n_fb     = 1'b0;
                    n_slot   = '0;
                    n_issue  = 1'b1;
                    n_total  = '0;
                    n_found  = 1'b0;
                    n_chosen = '0;
                end
            end
            wpts_pkg::S_SUM: begin
                if (r_rd_vld) begin
                    n_total = sum;
                    if (r_rd_last) begin
                        priority if (sum != '0) begin
                            mod_start = 1'b1;
                            n_state   = wpts_pkg::S_DIV;
                        end else if (!r_fb) begin
                            if (r_group == last_group) begin
                                n_fb = 1'b1;
                            end else begin
                                n_group = r_group + 1'b1;
                            end
                            n_total = '0;
                            n_slot  = '0;
                            n_issue = 1'b1;
                        end else begin
                            n_found  = 1'b0;
                            n_chosen = '0;
                            n_state  = wpts_pkg::S_DONE;
                        end
                    end
                end
            end
            wpts_pkg::S_DIV: begin
                if (mod_done) begin
                    n_sel   = mod_rem;
                    n_slot  = '0;
                    n_issue = 1'b1;
                    n_state = wpts_pkg::S_WALK;
                end
            end
            wpts_pkg::S_WALK: begin
                if (r_rd_vld) begin
                    if (walk_hit || r_rd_last) begin
                        n_found  = 1'b1;
                        n_chosen = r_rd_slot;
                        n_issue  = 1'b0;
                        n_state  = wpts_pkg::S_DONE;
                    end else begin
                        n_sel = r_sel - w_ext;
                    end
                end
            end
            wpts_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = wpts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wpts_pkg::S_IDLE;
                n_issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= wpts_pkg::S_IDLE;
            r_group_count <= wpts_pkg::CFG_W'(1);
            r_valid       <= '0;
            r_issue       <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_rd_vld <= r_issue;
            if (i_cfg_valid && o_cfg_ready) begin
                r_group_count <= i_cfg_data;
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rnd  <= i_in_item.random_word;
            r_mask <= i_in_item.healthy_mask;
        end
        r_group     <= n_group;
        r_fb        <= n_fb;
        r_slot      <= n_slot;
        r_total     <= n_total;
        r_sel       <= n_sel;
        r_found     <= n_found;
        r_chosen    <= n_chosen;
        r_rd_slot   <= r_slot;
        r_rd_last   <= (r_slot == SLOT_W'(SLOTS - 1));
        r_rd_health <= rd_health;
        r_rd_vbit   <= r_valid[rd_addr];
        if (out_load) begin
            r_out.found        <= r_found;
            r_out.chosen_group <= wpts_pkg::FIELD_GW'(r_group);
            r_out.chosen_slot  <= wpts_pkg::FIELD_SW'(r_chosen);
            r_out.fell_back    <= r_fb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == wpts_pkg::S_IDLE))
        else $error("table write outside idle");

    a_select_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_item.opcode == wpts_pkg::OP_SELECT))
        |=> (r_state == wpts_pkg::S_SUM))
        else $error("select did not start summing");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wpts_pkg::S_WALK) && r_rd_vld && (r_rd_slot == '0))
        |-> (r_sel < r_total))
        else $error("selector not below weight sum");

    a_walk_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wpts_pkg::S_WALK) && r_rd_vld && r_rd_last) |-> walk_hit)
        else $error("walk ran past the last slot");

    a_mod_only_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |-> ((r_state == wpts_pkg::S_SUM) && !r_issue))
        else $error("modulo started outside sum end");

endmodule

// ===== rtl/wpts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpts_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module wpts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wpts_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpts_mod: serial modulo unit
// Restoring remainder of the random word by the weight sum, one bit a cycle.
// ----------------------------------------------------------------------------
module wpts_mod #(
    parameter int TOT_W = 34
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wpts_pkg::RND_W-1:0] i_dividend,
    input  logic [TOT_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [TOT_W-1:0]          o_rem
);

    localparam int CNT_W = $clog2(wpts_pkg::RND_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [wpts_pkg::RND_W-1:0] r_dvd;
    logic [TOT_W-1:0]           r_dsr;
    logic [TOT_W-1:0]           r_rem;
    logic [TOT_W:0]             trial;
    logic [TOT_W-1:0]           n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[wpts_pkg::RND_W-1]};
        if (trial >= {1'b0, r_dsr}) begin
            n_rem = TOT_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[TOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(wpts_pkg::RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[wpts_pkg::RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("modulo started while busy");

    a_nonzero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_divisor != '0))
        else $error("modulo started with zero divisor");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still busy");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dsr))
        else $error("remainder not below divisor");

endmodule
